### hw/rtl/obm_pkg.sv
`timescale 1ns / 1ps
package obm_pkg;

    typedef enum logic {
        BANK_A,
        BANK_B
    } obm_bank_t;

    typedef struct packed {
        logic x_hit;
        logic y_hit;
    } obm_touch_t;

endpackage

### hw/rtl/obm_ram.sv
`timescale 1ns / 1ps
module obm_ram #(
    parameter int WIDTH = 50,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### hw/rtl/obm_geom.sv
`timescale 1ns / 1ps
module obm_geom
    import obm_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic [4*COORD_BITS+1:0] a_box,
    input  logic [4*COORD_BITS+1:0] b_box,
    output obm_touch_t              touch,
    output logic [4*COORD_BITS+1:0] bound
);

    localparam int C  = COORD_BITS;
    localparam int S  = COORD_BITS + 1;
    localparam int E  = COORD_BITS + 2;
    localparam int DW = 4 * COORD_BITS + 2;

    logic [C-1:0] ax, ay, bx, by, lx, ly;
    logic [S-1:0] aw, ah, bw, bh;
    logic [E-1:0] cax, cbx, cay, cby, dx, dy, sx, sy;
    logic [E-1:0] rax, rbx, bay, bby, rx, ry;

    assign ax = a_box[DW-1 -: C];
    assign ay = a_box[DW-1-C -: C];
    assign aw = a_box[2*S-1 -: S];
    assign ah = a_box[S-1:0];
    assign bx = b_box[DW-1 -: C];
    assign by = b_box[DW-1-C -: C];
    assign bw = b_box[2*S-1 -: S];
    assign bh = b_box[S-1:0];

    assign cax = E'({ax, 1'b0}) + E'(aw);
    assign cbx = E'({bx, 1'b0}) + E'(bw);
    assign cay = E'({ay, 1'b0}) + E'(ah);
    assign cby = E'({by, 1'b0}) + E'(bh);
    assign dx  = (cax >= cbx) ? cax - cbx : cbx - cax;
    assign dy  = (cay >= cby) ? cay - cby : cby - cay;
    assign sx  = E'(aw) + E'(bw);
    assign sy  = E'(ah) + E'(bh);

    assign touch.x_hit = (dx <= sx);
    assign touch.y_hit = (dy <= sy);

    assign lx  = (ax < bx) ? ax : bx;
    assign ly  = (ay < by) ? ay : by;
    assign rax = E'(ax) + E'(aw);
    assign rbx = E'(bx) + E'(bw);
    assign bay = E'(ay) + E'(ah);
    assign bby = E'(by) + E'(bh);
    assign rx  = (rax > rbx) ? rax : rbx;
    assign ry  = (bay > bby) ? bay : bby;

    assign bound = {lx, ly, S'(rx - E'(lx)), S'(ry - E'(ly))};

endmodule

### hw/rtl/overlapping_box_merge_unit.sv
`timescale 1ns / 1ps
// Overlapping box merge unit.
// Input channel (in_valid / in_stall): one box word per cycle, box_x, box_y,
// box_width, box_height and final_box. Boxes load at one word per cycle while
// the unit collects a set; up to MAX_BOXES are kept, the rest are dropped and
// reported on dropped_boxes. The word with final_box set closes the set.
// After that the input stalls while the unit merges: each pass walks the box
// list held in a ping-pong pair of RAMs, fetching box i, then scanning later
// boxes j one at a time, skipping those already merged, and merging box i
// with the first that touches it; passes repeat until one merges nothing.
// The final list then leaves on the output channel (out_valid / out_stall),
// one word at a time, the next word read only after the last is taken, with
// end_of_list on the last word. A stalled output word holds until taken.
// After the last word the unit returns to loading a new set.
// Reset clears the set and the overflow flag. Each RAM word carries its free
// flag, set when a box is written to a list, cleared when it is merged away,
// so the RAMs need no clearing pass.
module overlapping_box_merge_unit
    import obm_pkg::*;
#(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_BITS-1:0] box_x,
    input  logic [COORD_BITS-1:0] box_y,
    input  logic [COORD_BITS-1:0] box_width,
    input  logic [COORD_BITS-1:0] box_height,
    input  logic                  final_box,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COORD_BITS-1:0] out_x,
    output logic [COORD_BITS-1:0] out_y,
    output logic [COORD_BITS:0]   out_width,
    output logic [COORD_BITS:0]   out_height,
    output logic                  end_of_list,
    output logic                  dropped_boxes
);

    localparam int C  = COORD_BITS;
    localparam int S  = COORD_BITS + 1;
    localparam int DW = 4 * COORD_BITS + 2;
    localparam int FW = DW + 1;
    localparam int AW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PASS,
        ST_ICHK,
        ST_IWAIT,
        ST_JCHK,
        ST_JWAIT,
        ST_JTEST,
        ST_MERGE,
        ST_MARK,
        ST_ERD,
        ST_EWAIT,
        ST_EHOLD
    } state_t;

    state_t                 state_reg;
    obm_bank_t              bank_reg;
    logic [CW-1:0]          count_reg, i_reg, j_reg, m_reg;
    logic                   merged_reg, overflow_reg;
    logic [DW-1:0]          a_reg, b_reg;
    logic                   out_valid_reg, last_reg;
    logic [DW-1:0]          out_reg;

    logic                   we;
    obm_bank_t              wr_bank;
    logic [AW-1:0]          wr_addr, rd_addr;
    logic [FW-1:0]          wr_data, rd_a, rd_b, rd_data;
    obm_touch_t             touch;
    logic [DW-1:0]          bound;
    logic                   load_go;

    assign in_stall = (state_reg != ST_LOAD);
    assign load_go  = in_valid && !in_stall;

    always_comb
    begin
        we      = 1'b0;
        wr_bank = (bank_reg == BANK_A) ? BANK_B : BANK_A;
        wr_addr = m_reg[AW-1:0];
        wr_data = {1'b1, a_reg};
        rd_addr = i_reg[AW-1:0];
        case (state_reg)
            ST_LOAD:
            begin
                we      = load_go && (count_reg < CW'(MAX_BOXES));
                wr_bank = bank_reg;
                wr_addr = count_reg[AW-1:0];
                wr_data = {1'b1, box_x, box_y, S'(box_width), S'(box_height)};
            end
            ST_JCHK:
            begin
                rd_addr = j_reg[AW-1:0];
                we      = (j_reg == count_reg);
            end
            ST_MERGE:
            begin
                we      = 1'b1;
                wr_data = {1'b1, bound};
            end
            ST_MARK:
            begin
                we      = 1'b1;
                wr_bank = bank_reg;
                wr_addr = j_reg[AW-1:0];
                wr_data = {1'b0, b_reg};
            end
            ST_ERD:
            begin
                rd_addr = i_reg[AW-1:0];
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    obm_ram #(.WIDTH(FW), .DEPTH(MAX_BOXES)) u_ram_a (
        .clk     (clk),
        .we      (we && (wr_bank == BANK_A)),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_a)
    );

    obm_ram #(.WIDTH(FW), .DEPTH(MAX_BOXES)) u_ram_b (
        .clk     (clk),
        .we      (we && (wr_bank == BANK_B)),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_b)
    );

    assign rd_data = (bank_reg == BANK_A) ? rd_a : rd_b;

    obm_geom #(.COORD_BITS(COORD_BITS)) u_geom (
        .a_box (a_reg),
        .b_box (b_reg),
        .touch (touch),
        .bound (bound)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            bank_reg      <= BANK_A;
            count_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            m_reg         <= '0;
            merged_reg    <= 1'b0;
            overflow_reg  <= 1'b0;
            a_reg         <= '0;
            b_reg         <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            case (state_reg)
                ST_LOAD:
                begin
                    if (load_go)
                    begin
                        if (count_reg < CW'(MAX_BOXES))
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        else
                        begin
                            overflow_reg <= 1'b1;
                        end
                        if (final_box)
                        begin
                            state_reg <= ST_PASS;
                        end
                    end
                end
                ST_PASS:
                begin
                    i_reg      <= '0;
                    m_reg      <= '0;
                    merged_reg <= 1'b0;
                    state_reg  <= ST_ICHK;
                end
                ST_ICHK:
                begin
                    if (i_reg == count_reg)
                    begin
                        count_reg <= m_reg;
                        bank_reg  <= (bank_reg == BANK_A) ? BANK_B : BANK_A;
                        i_reg     <= '0;
                        state_reg <= merged_reg ? ST_PASS : ST_ERD;
                    end
                    else
                    begin
                        state_reg <= ST_IWAIT;
                    end
                end
                ST_IWAIT:
                begin
                    a_reg <= rd_data[DW-1:0];
                    if (rd_data[DW])
                    begin
                        j_reg     <= i_reg + 1'b1;
                        state_reg <= ST_JCHK;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_ICHK;
                    end
                end
                ST_JCHK:
                begin
                    if (j_reg == count_reg)
                    begin
                        m_reg     <= m_reg + 1'b1;
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_ICHK;
                    end
                    else
                    begin
                        state_reg <= ST_JWAIT;
                    end
                end
                ST_JWAIT:
                begin
                    b_reg <= rd_data[DW-1:0];
                    if (rd_data[DW])
                    begin
                        state_reg <= ST_JTEST;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_JCHK;
                    end
                end
                ST_JTEST:
                begin
                    if (touch.x_hit && touch.y_hit)
                    begin
                        state_reg <= ST_MERGE;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_JCHK;
                    end
                end
                ST_MERGE:
                begin
                    merged_reg <= 1'b1;
                    m_reg      <= m_reg + 1'b1;
                    i_reg      <= i_reg + 1'b1;
                    state_reg  <= ST_MARK;
                end
                ST_MARK:
                begin
                    state_reg <= ST_ICHK;
                end
                ST_ERD:
                begin
                    state_reg <= ST_EWAIT;
                end
                ST_EWAIT:
                begin
                    out_reg       <= rd_data[DW-1:0];
                    out_valid_reg <= 1'b1;
                    last_reg      <= ((i_reg + 1'b1) == count_reg);
                    state_reg     <= ST_EHOLD;
                end
                ST_EHOLD:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        if (last_reg)
                        begin
                            count_reg    <= '0;
                            overflow_reg <= 1'b0;
                            i_reg        <= '0;
                            state_reg    <= ST_LOAD;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= ST_ERD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_x         = out_reg[DW-1 -: C];
    assign out_y         = out_reg[DW-1-C -: C];
    assign out_width     = out_reg[2*S-1 -: S];
    assign out_height    = out_reg[S-1:0];
    assign end_of_list   = last_reg;
    assign dropped_boxes = overflow_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MERGE) |-> (touch.x_hit && touch.y_hit))
    else $error("merge without touching pair");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_BOXES))
    else $error("box count beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ICHK) |-> (m_reg <= i_reg))
    else $error("write index ahead of read index");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == ST_EHOLD))
    else $error("output word outside emit");
`endif

endmodule
